// ===== rtl/rdma_queue_pair_completion_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the completion engine modules.
// Every macro samples on clk and is switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef RDMA_QUEUE_PAIR_COMPLETION_ENGINE_DEFINES_SVH
`define RDMA_QUEUE_PAIR_COMPLETION_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RQPC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RQPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rqpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rqpc_pkg
// Sizes, command codes and shared types of the queue-pair completion engine.
// ----------------------------------------------------------------------------
package rqpc_pkg;

  // Table and ring sizes.
  localparam int MAX_PAIRS   = 16;
  localparam int MAX_REGIONS = 16;
  localparam int RING_DEPTH  = 64;
  localparam int QUEUE_DEPTH = 2;

  // Field widths fixed by the command format.
  localparam int OPC_W   = 3;
  localparam int QPN_W   = 4;
  localparam int STATE_W = 3;
  localparam int LEN_W   = 31;
  localparam int ADDR_W  = 64;
  localparam int VALUE_W = 32;

  // Derived widths.
  localparam int PAIR_IW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int PCNT_W   = $clog2(MAX_PAIRS + 1);
  localparam int RCNT_W   = $clog2(MAX_REGIONS + 1);
  localparam int RING_IW  = $clog2(RING_DEPTH);
  localparam int FILL_W   = $clog2(RING_DEPTH + 1);
  localparam int QCMP_W   = (PCNT_W > QPN_W) ? PCNT_W : QPN_W;
  localparam int QUEUE_IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  // Opcodes as they arrive on the command channel.
  localparam logic [OPC_W-1:0] OPC_REGION  = 3'd0;
  localparam logic [OPC_W-1:0] OPC_CREATE  = 3'd1;
  localparam logic [OPC_W-1:0] OPC_MODIFY  = 3'd2;
  localparam logic [OPC_W-1:0] OPC_POST    = 3'd3;
  localparam logic [OPC_W-1:0] OPC_POLL    = 3'd4;
  localparam logic [OPC_W-1:0] OPC_RWRITE  = 3'd5;

  // Pair state that allows sends.
  localparam logic [STATE_W-1:0] QP_STATE_RTS = 3'd3;

  // Command class after decoding.
  typedef enum logic [2:0] {
    CMD_REGION,
    CMD_CREATE,
    CMD_MODIFY,
    CMD_POST,
    CMD_POLL,
    CMD_RWRITE,
    CMD_BAD
  } cmd_kind_t;

  // Decoded command as held in the queue.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [QPN_W-1:0]   qpn;
    logic [STATE_W-1:0] state;
    logic               is_write;
    logic [LEN_W-1:0]   len;
    logic               len_ok;
    logic               target_ok;
    logic               source_ok;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_POLL
  } back_state_t;

endpackage

// ===== rtl/rqpc_front.sv =====
// ----------------------------------------------------------------------------
// rqpc_front
// Command decoder: classifies the opcode and derives validity flags from the
// address and length fields before the command enters the queue.
// ----------------------------------------------------------------------------
module rqpc_front (
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic [rqpc_pkg::OPC_W-1:0]      opcode,
  input  logic [rqpc_pkg::QPN_W-1:0]      qp_number,
  input  logic [rqpc_pkg::STATE_W-1:0]    qp_state,
  input  logic                            work_is_write,
  input  logic [rqpc_pkg::LEN_W-1:0]      length,
  input  logic [rqpc_pkg::ADDR_W-1:0]     target_address,
  input  logic [rqpc_pkg::ADDR_W-1:0]     source_address,
  output logic                            push_valid,
  output rqpc_pkg::cmd_t                  push_cmd,
  input  logic                            queue_full
);
  import rqpc_pkg::*;

  // The queue takes a transfer whenever it has room.
  assign cmd_stall  = queue_full;
  assign push_valid = cmd_valid;

  // Opcode classification and field checks.
  always_comb begin
    push_cmd.qpn       = qp_number;
    push_cmd.state     = qp_state;
    push_cmd.is_write  = work_is_write;
    push_cmd.len       = length;
    push_cmd.len_ok    = (length != '0);
    push_cmd.target_ok = (target_address != '0);
    push_cmd.source_ok = (source_address != '0);
    unique case (opcode)
      OPC_REGION: push_cmd.kind = CMD_REGION;
      OPC_CREATE: push_cmd.kind = CMD_CREATE;
      OPC_MODIFY: push_cmd.kind = CMD_MODIFY;
      OPC_POST:   push_cmd.kind = CMD_POST;
      OPC_POLL:   push_cmd.kind = CMD_POLL;
      OPC_RWRITE: push_cmd.kind = CMD_RWRITE;
      default:    push_cmd.kind = CMD_BAD;
    endcase
  end

endmodule

// ===== rtl/rqpc_queue.sv =====
// ----------------------------------------------------------------------------
// rqpc_queue
// Short command queue that decouples the decoder from the executing back end.
// ----------------------------------------------------------------------------
module rqpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  rqpc_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           pop_valid,
  output rqpc_pkg::cmd_t pop_cmd,
  input  logic           pop
);
  import rqpc_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_IW-1:0] wr_ptr;
  logic [QUEUE_IW-1:0] rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/rqpc_back.sv =====
// ----------------------------------------------------------------------------
// rqpc_back
// Command executor: holds the pair table, the counters and the completion
// ring, and drives the registered result.
// ----------------------------------------------------------------------------
`include "rdma_queue_pair_completion_engine_defines.svh"

module rqpc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  rqpc_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         failed,
  output logic [rqpc_pkg::VALUE_W-1:0] value
);
  import rqpc_pkg::*;

  back_state_t         state;
  back_state_t         state_next;
  logic [STATE_W-1:0]  pair_states [MAX_PAIRS];
  logic [PCNT_W-1:0]   pair_count;
  logic [RCNT_W-1:0]   region_count;
  logic [VALUE_W-1:0]  ring_mem [RING_DEPTH];
  logic [VALUE_W-1:0]  ring_rd_data;
  logic [RING_IW-1:0]  ring_head;
  logic [RING_IW-1:0]  ring_tail;
  logic [FILL_W-1:0]   ring_fill;

  logic                out_free;
  logic                load;
  logic                load_failed;
  logic [VALUE_W-1:0]  load_value;
  logic                push_en;
  logic [VALUE_W-1:0]  push_val;
  logic                take_en;
  logic                region_inc;
  logic                create_en;
  logic                modify_en;
  logic [QCMP_W-1:0]   qpn_ext;
  logic [PAIR_IW-1:0]  qidx;
  logic                pair_exists;
  logic                pair_rts;
  logic                ring_full;

  assign out_free    = !rsp_valid || !rsp_stall;
  assign qpn_ext     = QCMP_W'(q_cmd.qpn);
  assign qidx        = qpn_ext[PAIR_IW-1:0];
  assign pair_exists = (qpn_ext < QCMP_W'(pair_count));
  assign pair_rts    = pair_exists && (pair_states[qidx] == QP_STATE_RTS);
  assign ring_full   = (ring_fill == FILL_W'(RING_DEPTH));

  // Sequencer: next state and the actions of the current command.
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    load        = 1'b0;
    load_failed = 1'b1;
    load_value  = '0;
    push_en     = 1'b0;
    push_val    = '0;
    take_en     = 1'b0;
    region_inc  = 1'b0;
    create_en   = 1'b0;
    modify_en   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_REGION: begin
              load = 1'b1;
              if (region_count < RCNT_W'(MAX_REGIONS) && q_cmd.target_ok &&
                  q_cmd.len_ok) begin
                region_inc  = 1'b1;
                load_failed = 1'b0;
              end
            end
            CMD_CREATE: begin
              load = 1'b1;
              if (pair_count < PCNT_W'(MAX_PAIRS)) begin
                create_en   = 1'b1;
                load_failed = 1'b0;
                load_value  = VALUE_W'(pair_count);
              end
            end
            CMD_MODIFY: begin
              load = 1'b1;
              if (pair_exists) begin
                modify_en   = 1'b1;
                load_failed = 1'b0;
              end
            end
            CMD_POST: begin
              load = 1'b1;
              push_val = q_cmd.is_write ? VALUE_W'(q_cmd.len) : VALUE_W'(1);
              if (pair_rts && !ring_full) begin
                push_en     = 1'b1;
                load_failed = 1'b0;
              end
            end
            CMD_RWRITE: begin
              load = 1'b1;
              push_val = VALUE_W'(q_cmd.len);
              if (pair_rts && q_cmd.target_ok && q_cmd.source_ok && q_cmd.len_ok) begin
                push_en     = !ring_full;
                load_failed = 1'b0;
                load_value  = VALUE_W'(q_cmd.len);
              end
            end
            CMD_POLL: begin
              // A non-empty ring goes to BK_POLL to wait for the registered ring read.
              if (ring_fill != '0) begin
                state_next = BK_POLL;
              end else begin
                load = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      BK_POLL: begin
        if (out_free) begin
          load        = 1'b1;
          load_failed = 1'b0;
          load_value  = ring_rd_data;
          take_en     = 1'b1;
          state_next  = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Control state: sequencer, counters, ring pointers and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      pair_count   <= '0;
      region_count <= '0;
      ring_head    <= '0;
      ring_tail    <= '0;
      ring_fill    <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (region_inc) begin
        region_count <= region_count + 1'b1;
      end
      if (create_en) begin
        pair_count <= pair_count + 1'b1;
      end
      if (push_en) begin
        ring_tail <= (ring_tail == RING_IW'(RING_DEPTH - 1)) ? '0 : ring_tail + 1'b1;
        ring_fill <= ring_fill + 1'b1;
      end else if (take_en) begin
        ring_head <= (ring_head == RING_IW'(RING_DEPTH - 1)) ? '0 : ring_head + 1'b1;
        ring_fill <= ring_fill - 1'b1;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      failed <= load_failed;
      value  <= load_value;
    end
  end

  // Pair state table.
  always_ff @(posedge clk) begin
    if (create_en) begin
      pair_states[pair_count[PAIR_IW-1:0]] <= q_cmd.state;
    end else if (modify_en) begin
      pair_states[qidx] <= q_cmd.state;
    end
  end

  // Completion ring memory with a registered read at the head.
  always_ff @(posedge clk) begin
    if (push_en) begin
      ring_mem[ring_tail] <= push_val;
    end
    ring_rd_data <= ring_mem[ring_head];
  end

  // Checks on the ring and the counters.
  `RQPC_ASSERT_IMPL(a_fill_bound, 1'b1, ring_fill <= FILL_W'(RING_DEPTH), "ring overfilled")
  `RQPC_ASSERT_IMPL(a_poll_nonempty, state == BK_POLL, ring_fill != '0, "poll of empty ring")
  `RQPC_ASSERT_IMPL(a_empty_ptrs, ring_fill == '0, ring_head == ring_tail, "empty ring pointers")
  `RQPC_ASSERT_IMPL(a_regions, 1'b1, region_count <= RCNT_W'(MAX_REGIONS), "region overflow")
  `RQPC_ASSERT_NEXT(a_push_fill, push_en, ring_fill != '0, "push left ring empty")

endmodule

// ===== rtl/rdma_queue_pair_completion_engine.sv =====
// ----------------------------------------------------------------------------
// rdma_queue_pair_completion_engine
// Queue-pair command engine with region and pair tables and a completion ring.
//
//   channel | direction | handshake            | payload
//   cmd     | in        | cmd_valid, cmd_stall | opcode .. source_address
//   rsp     | out       | rsp_valid, rsp_stall | failed, value
//
// The decoder takes one command transfer per cycle into a two-entry queue while the queue is not full.
// The executor finishes most commands from BK_IDLE; a poll of a non-empty
// ring passes through BK_POLL for the registered read of the ring memory.
// A command's result is registered when the executor takes it from the queue,
// or from BK_POLL for a poll of a non-empty ring.
// rst is synchronous and clears all control state; no clearing pass is run.
// A stalled result holds the executor; the queue then fills and stalls cmd.
// ----------------------------------------------------------------------------
module rdma_queue_pair_completion_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [rqpc_pkg::OPC_W-1:0]   opcode,
  input  logic [rqpc_pkg::QPN_W-1:0]   qp_number,
  input  logic [rqpc_pkg::STATE_W-1:0] qp_state,
  input  logic                         work_is_write,
  input  logic [rqpc_pkg::LEN_W-1:0]   length,
  input  logic [rqpc_pkg::ADDR_W-1:0]  target_address,
  input  logic [rqpc_pkg::ADDR_W-1:0]  source_address,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         failed,
  output logic [rqpc_pkg::VALUE_W-1:0] value
);
  import rqpc_pkg::*;

  logic push_valid;
  cmd_t push_cmd;
  logic queue_full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // Decoder.
  rqpc_front u_front (
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .opcode         (opcode),
    .qp_number      (qp_number),
    .qp_state       (qp_state),
    .work_is_write  (work_is_write),
    .length         (length),
    .target_address (target_address),
    .source_address (source_address),
    .push_valid     (push_valid),
    .push_cmd       (push_cmd),
    .queue_full     (queue_full)
  );

  // Command queue.
  rqpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop        (q_pop)
  );

  // Executor.
  rqpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .failed    (failed),
    .value     (value)
  );

endmodule
